[rtl/qte_pkg.sv]
// Shared types, fixed-point constants and the arctangent table of the quaternion converter.
package qte_pkg;

  // Internal formats: components in Q1.24, products and sums in Q.48, angles in Q.16.
  localparam int FRAC    = 24;
  localparam int CW      = 54;
  localparam int AGW     = 20;
  localparam int NSTEP   = 16;
  localparam int RAD_W   = 50;
  localparam int ROOT_W  = 25;
  localparam int REM_W   = 27;
  localparam int PROD_W  = 2 * FRAC + 2;

  localparam logic signed [CW-1:0]  ONE_Q48     = CW'(64'sd1 <<< (2 * FRAC));
  localparam logic signed [CW-1:0]  HALF_Q48    = CW'(64'sd1 <<< (2 * FRAC - 1));
  localparam logic signed [AGW-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [AGW-1:0] HALF_PI_Q16 = 20'sd102944;

  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [AGW-1:0] ang;
    logic                  zero;
  } vec_t;

  typedef struct packed {
    logic [RAD_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    sq_t  a;
    sq_t  b;
    vec_t roll;
    vec_t yaw;
    logic clamped;
  } sqp_t;

  typedef struct packed {
    vec_t roll;
    vec_t yaw;
    vec_t pitch;
    logic clamped;
  } cp_t;

  // Rounded atan(2^-i) in Q.16.
  function automatic logic signed [AGW-1:0] atan_q16(input int unsigned i);
    logic signed [AGW-1:0] t;
    case (i)
      0:       t = 20'sd51472;
      1:       t = 20'sd30386;
      2:       t = 20'sd16055;
      3:       t = 20'sd8150;
      4:       t = 20'sd4091;
      5:       t = 20'sd2047;
      6:       t = 20'sd1024;
      7:       t = 20'sd512;
      8:       t = 20'sd256;
      9:       t = 20'sd128;
      10:      t = 20'sd64;
      11:      t = 20'sd32;
      12:      t = 20'sd16;
      13:      t = 20'sd8;
      14:      t = 20'sd4;
      15:      t = 20'sd2;
      default: t = 20'sd0;
    endcase
    return t;
  endfunction

endpackage

[rtl/quaternion_to_euler_angles_top.sv]
// Top level of the quaternion to roll, pitch and yaw converter.
//
//   Channel   Ports                                   Handshake
//   input     in_quat_w/x/y/z (signed Q1.15)          in_valid, in_stall
//   result    out_roll, out_yaw (Q3.13), out_pitch     out_valid, out_stall
//             (Q2.13), out_pitch_clamped
//
// The block takes one transaction per cycle while in_stall is low; each result passes
// through the chain of cells: four front stages, 25 square root digit cells, 16 CORDIC
// cells and two back stages, then the output register.
// Reset (rst_n, synchronous, active low) clears the valid bits of the chain and of the
// output side; no data register is reset.
// A stalled result waits in the output register while one more transaction can still be
// taken into a skid register; the chain halts only while the skid register is full.
module quaternion_to_euler_angles_top import qte_pkg::*; #(
  parameter int QUAT_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_w,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANGLE_WIDTH-1:0] out_roll,
  output logic signed [ANGLE_WIDTH-2:0] out_pitch,
  output logic signed [ANGLE_WIDTH-1:0] out_yaw,
  output logic                          out_pitch_clamped
);

  // Number of registered stages between the input port and the output buffer.
  localparam int NSTG = 4 + ROOT_W + NSTEP + 2;

  logic            en;
  logic [NSTG-1:0] v_r;
  sqp_t            sq_bus [ROOT_W+1];
  cp_t             cp_bus [NSTEP+1];

  logic signed [ANGLE_WIDTH-1:0] b_roll, b_yaw;
  logic signed [ANGLE_WIDTH-2:0] b_pitch;
  logic                          b_clamped;

  logic                          out_valid_r, sk_valid_r;
  logic signed [ANGLE_WIDTH-1:0] out_roll_r, out_yaw_r, sk_roll_r, sk_yaw_r;
  logic signed [ANGLE_WIDTH-2:0] out_pitch_r, sk_pitch_r;
  logic                          out_clamped_r, sk_clamped_r;
  logic                          take_out, incoming;

  // The whole chain moves together whenever the skid register has room.
  assign en       = !sk_valid_r;
  assign in_stall = sk_valid_r;

  qte_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
    .clk    (clk),
    .en     (en),
    .quat_w (in_quat_w),
    .quat_x (in_quat_x),
    .quat_y (in_quat_y),
    .quat_z (in_quat_z),
    .sq_o   (sq_bus[0])
  );

  // Square root cells: one root bit of both pitch radicands per cell.
  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq_bus[g]),
      .q   (sq_bus[g+1])
    );
  end

  // The finished roots form the pitch vector; roll and yaw come through unchanged.
  always_comb begin
    cp_bus[0].roll       = sq_bus[ROOT_W].roll;
    cp_bus[0].yaw        = sq_bus[ROOT_W].yaw;
    cp_bus[0].pitch.x    = CW'(sq_bus[ROOT_W].a.root);
    cp_bus[0].pitch.y    = CW'(sq_bus[ROOT_W].b.root);
    cp_bus[0].pitch.ang  = '0;
    cp_bus[0].pitch.zero = 1'b0;
    cp_bus[0].clamped    = sq_bus[ROOT_W].clamped;
  end

  // CORDIC cells: step g of all three vectoring lanes.
  for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
    qte_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (cp_bus[g]),
      .q   (cp_bus[g+1])
    );
  end

  qte_back #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
    .clk     (clk),
    .en      (en),
    .d       (cp_bus[NSTEP]),
    .roll    (b_roll),
    .pitch   (b_pitch),
    .yaw     (b_yaw),
    .clamped (b_clamped)
  );

  // Valid bits travel alongside the data, one per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  assign take_out = out_valid_r && !out_stall;
  assign incoming = en && v_r[NSTG-1];

  // Output register plus skid register. A transaction leaving the chain goes to the output
  // register when that is free or being emptied, and to the skid register otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (sk_valid_r) begin
      if (take_out) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid_r || take_out) begin
        out_valid_r <= 1'b1;
      end else begin
        sk_valid_r <= 1'b1;
      end
    end else if (take_out) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid_r) begin
      if (take_out) begin
        out_roll_r    <= sk_roll_r;
        out_pitch_r   <= sk_pitch_r;
        out_yaw_r     <= sk_yaw_r;
        out_clamped_r <= sk_clamped_r;
      end
    end else if (incoming) begin
      if (!out_valid_r || take_out) begin
        out_roll_r    <= b_roll;
        out_pitch_r   <= b_pitch;
        out_yaw_r     <= b_yaw;
        out_clamped_r <= b_clamped;
      end else begin
        sk_roll_r    <= b_roll;
        sk_pitch_r   <= b_pitch;
        sk_yaw_r     <= b_yaw;
        sk_clamped_r <= b_clamped;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_roll          = out_roll_r;
  assign out_pitch         = out_pitch_r;
  assign out_yaw           = out_yaw_r;
  assign out_pitch_clamped = out_clamped_r;

endmodule

[rtl/qte_front.sv]
// Front stages: component load, products, product sums with pitch clamp, and pre-rotation.
module qte_front import qte_pkg::*; #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  output sqp_t                         sq_o
);

  localparam int SHL = (QUAT_WIDTH - 1 <= FRAC) ? FRAC - (QUAT_WIDTH - 1) : 0;
  localparam int SHR = (QUAT_WIDTH - 1 > FRAC) ? (QUAT_WIDTH - 1) - FRAC : 0;
  localparam int EW  = 58;

  function automatic logic signed [FRAC:0] load(input logic signed [QUAT_WIDTH-1:0] v);
    logic signed [EW-1:0] e;
    e = (EW'(v) <<< SHL) >>> SHR;
    return e[FRAC:0];
  endfunction

  // Fold the left half plane onto the right one, as the vectoring loop needs X >= 0.
  function automatic vec_t prep(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      v.x   = -x;
      v.y   = -y;
      v.ang = (y >= 0) ? PI_Q16 : -PI_Q16;
    end else begin
      v.x   = x;
      v.y   = y;
      v.ang = '0;
    end
    return v;
  endfunction

  logic signed [FRAC:0]     w_r, x_r, y_r, z_r;
  logic signed [PROD_W-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, xz_r;
  logic signed [CW-1:0]     rx_r, ry_r, yx_r, yy2_r;
  logic [RAD_W-1:0]         rada_r, radb_r;
  logic                     clamp_r;
  logic signed [CW-1:0]     rx_nxt, ry_nxt, yx_nxt, yy2_nxt, s_v;
  logic [RAD_W-1:0]         rada_nxt, radb_nxt;
  logic                     clamp_nxt;
  sqp_t                     sq_r, sq_nxt;

  always_comb begin
    rx_nxt  = (CW'(wx_r) + CW'(yz_r)) <<< 1;
    ry_nxt  = ONE_Q48 - ((CW'(xx_r) + CW'(yy_r)) <<< 1);
    yx_nxt  = (CW'(wz_r) + CW'(xy_r)) <<< 1;
    yy2_nxt = ONE_Q48 - ((CW'(yy_r) + CW'(zz_r)) <<< 1);
    s_v       = CW'(wy_r) - CW'(xz_r);
    clamp_nxt = 1'b0;
    if (s_v > HALF_Q48) begin
      s_v       = HALF_Q48;
      clamp_nxt = 1'b1;
    end else if (s_v < -HALF_Q48) begin
      s_v       = -HALF_Q48;
      clamp_nxt = 1'b1;
    end
    rada_nxt = RAD_W'(ONE_Q48 + (s_v <<< 1));
    radb_nxt = RAD_W'(ONE_Q48 - (s_v <<< 1));
  end

  always_comb begin
    sq_nxt.a.n     = rada_r;
    sq_nxt.a.rem   = '0;
    sq_nxt.a.root  = '0;
    sq_nxt.b.n     = radb_r;
    sq_nxt.b.rem   = '0;
    sq_nxt.b.root  = '0;
    sq_nxt.roll    = prep(rx_r, ry_r);
    sq_nxt.yaw     = prep(yx_r, yy2_r);
    sq_nxt.clamped = clamp_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r     <= load(quat_w);
      x_r     <= load(quat_x);
      y_r     <= load(quat_y);
      z_r     <= load(quat_z);
      wx_r    <= w_r * x_r;
      yz_r    <= y_r * z_r;
      xx_r    <= x_r * x_r;
      yy_r    <= y_r * y_r;
      wz_r    <= w_r * z_r;
      xy_r    <= x_r * y_r;
      zz_r    <= z_r * z_r;
      wy_r    <= w_r * y_r;
      xz_r    <= x_r * z_r;
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      yx_r    <= yx_nxt;
      yy2_r   <= yy2_nxt;
      rada_r  <= rada_nxt;
      radb_r  <= radb_nxt;
      clamp_r <= clamp_nxt;
      sq_r    <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

[rtl/qte_sqrt_cell.sv]
// One digit cell of the two pitch square roots; carries the roll and yaw vectors along.
module qte_sqrt_cell import qte_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sqp_t d,
  output sqp_t q
);

  function automatic sq_t step(input sq_t s);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] tr;
    sq_t              o;
    r2 = {s.rem, s.n[RAD_W-1:RAD_W-2]};
    tr = {2'b00, s.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = REM_W'(r2 - tr);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(r2);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.n = s.n << 2;
    return o;
  endfunction

  sqp_t q_r, q_nxt;

  always_comb begin
    q_nxt   = d;
    q_nxt.a = step(d.a);
    q_nxt.b = step(d.b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/qte_cordic_cell.sv]
// One vectoring step of the three arctangent lanes.
module qte_cordic_cell import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  cp_t  d,
  output cp_t  q
);

  localparam logic signed [AGW-1:0] T = atan_q16(STEP);

  function automatic vec_t rot(input vec_t v);
    logic signed [CW-1:0]  xv, yv, dx, dy;
    logic signed [AGW-1:0] av;
    vec_t                  o;
    xv = v.x;
    yv = v.y;
    av = v.ang;
    dx = yv >>> STEP;
    dy = xv >>> STEP;
    if (yv > 0) begin
      o.x   = xv + dx;
      o.y   = yv - dy;
      o.ang = av + T;
    end else begin
      o.x   = xv - dx;
      o.y   = yv + dy;
      o.ang = av - T;
    end
    o.zero = v.zero;
    return o;
  endfunction

  cp_t q_r, q_nxt;

  always_comb begin
    q_nxt.roll    = rot(d.roll);
    q_nxt.yaw     = rot(d.yaw);
    q_nxt.pitch   = rot(d.pitch);
    q_nxt.clamped = d.clamped;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/qte_back.sv]
// Back stages: zero-vector and pitch fix-up, then output format conversion with saturation.
module qte_back import qte_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  cp_t                           d,
  output logic signed [ANGLE_WIDTH-1:0] roll,
  output logic signed [ANGLE_WIDTH-2:0] pitch,
  output logic signed [ANGLE_WIDTH-1:0] yaw,
  output logic                          clamped
);

  localparam int OFR = ANGLE_WIDTH - 3;
  localparam int SHR = (OFR <= 16) ? 16 - OFR : 0;
  localparam int SHL = (OFR > 16) ? OFR - 16 : 0;
  localparam int CVW = 40;
  localparam logic signed [CVW-1:0] RND = CVW'((64'sd1 <<< SHR) >>> 1);

  function automatic logic signed [CVW-1:0] conv(input logic signed [AGW-1:0] a);
    logic signed [CVW-1:0] e;
    e = ((CVW'(a) + RND) >>> SHR) <<< SHL;
    return e;
  endfunction

  function automatic logic signed [CVW-1:0] sat(input logic signed [CVW-1:0] v,
                                                input logic signed [CVW-1:0] lim);
    logic signed [CVW-1:0] o;
    if (v > lim) begin
      o = lim;
    end else if (v < -lim) begin
      o = -lim;
    end else begin
      o = v;
    end
    return o;
  endfunction

  localparam logic signed [CVW-1:0] LIM_PI  = conv(PI_Q16);
  localparam logic signed [CVW-1:0] LIM_HPI = conv(HALF_PI_Q16);

  logic signed [AGW-1:0]         ra_r, pa_r, ya_r;
  logic                          cl_r;
  logic signed [AGW-1:0]         ra_nxt, pa_nxt, ya_nxt, pin;
  logic signed [AGW+1:0]         pw;
  logic signed [CVW-1:0]         rc, pc, yc;
  logic signed [ANGLE_WIDTH-1:0] roll_r, yaw_r;
  logic signed [ANGLE_WIDTH-2:0] pitch_r;
  logic                          clamped_r;

  always_comb begin
    ra_nxt = d.roll.zero ? '0 : d.roll.ang;
    ya_nxt = d.yaw.zero ? '0 : d.yaw.ang;
    pin    = d.pitch.zero ? '0 : d.pitch.ang;
    pw     = ((AGW + 2)'(pin) <<< 1) - (AGW + 2)'(HALF_PI_Q16);
    pa_nxt = pw[AGW-1:0];
    rc     = sat(conv(ra_r), LIM_PI);
    yc     = sat(conv(ya_r), LIM_PI);
    pc     = sat(conv(pa_r), LIM_HPI);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r      <= ra_nxt;
      pa_r      <= pa_nxt;
      ya_r      <= ya_nxt;
      cl_r      <= d.clamped;
      roll_r    <= rc[ANGLE_WIDTH-1:0];
      pitch_r   <= pc[ANGLE_WIDTH-2:0];
      yaw_r     <= yc[ANGLE_WIDTH-1:0];
      clamped_r <= cl_r;
    end
  end

  assign roll    = roll_r;
  assign pitch   = pitch_r;
  assign yaw     = yaw_r;
  assign clamped = clamped_r;

endmodule

[verif/quaternion_to_euler_angles_top_tb.sv]
// Self-checking testbench of the quaternion to roll, pitch and yaw converter.
module quaternion_to_euler_angles_top_tb;

  localparam int QW = 16;
  localparam int AW = 16;
  // Angles in Q.16 as the arctangent works on them.
  localparam longint PI_A = 205887;
  localparam longint HPI_A = 102944;
  localparam int NUM_RANDOM = 1730;

  // One result transaction as it leaves the block.
  typedef struct {
    logic signed [AW-1:0] roll;
    logic signed [AW-2:0] pitch;
    logic signed [AW-1:0] yaw;
    logic                 clamped;
  } angles_t;

  // One directed row; has_exp marks rows whose result is typed in by hand.
  typedef struct {
    logic signed [QW-1:0] w, x, y, z;
    bit                   has_exp;
    angles_t              exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QW-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AW-1:0] out_roll, out_yaw;
  logic signed [AW-2:0] out_pitch;
  logic out_pitch_clamped;

  angles_t pending_angles[$];
  int      error_count = 0;
  bit      stim_done = 1'b0;
  // Set while the sender runs in the stretch where it never idles.
  bit      steady_sender = 1'b0;
  // Asks the receiver to hold off for a long stretch.
  bit      hold_request = 1'b0;

  always #1 clk = ~clk;

  quaternion_to_euler_angles_top #(.QUAT_WIDTH(QW), .ANGLE_WIDTH(AW)) i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_quat_w, .in_quat_x, .in_quat_y, .in_quat_z,
    .out_valid, .out_stall, .out_roll, .out_pitch, .out_yaw, .out_pitch_clamped
  );

  // Floor shift right of a signed value.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Floor square root, digit by digit.
  function automatic longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Four-quadrant arctangent of y over x by CORDIC vectoring, angle in Q.16.
  function automatic longint cordic_angle(longint xv, longint yv);
    longint steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
    longint a, dx, dy;
    a = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      a = (yv >= 0) ? PI_A : -PI_A;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(yv, i);
      dy = shr_floor(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; a += steps[i];
      end else begin
        xv -= dx; yv += dy; a -= steps[i];
      end
    end
    return a;
  endfunction

  // Q.16 angle to Q3.13 with rounding, then saturated to the given bound.
  function automatic longint q13_sat(longint a, longint lim);
    longint v;
    v = shr_floor(a + 4, 3);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Euler angles of one quaternion, computed in Q1.24 / Q.48 as the block does.
  function automatic angles_t euler_of(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                                       logic signed [QW-1:0] qy, logic signed [QW-1:0] qz);
    longint one, half, w, x, y, z, s, ra, rb;
    angles_t r;
    one = longint'(1) << 48;
    half = longint'(1) << 47;
    w = longint'(qw) <<< 9;
    x = longint'(qx) <<< 9;
    y = longint'(qy) <<< 9;
    z = longint'(qz) <<< 9;
    r.roll = AW'(q13_sat(cordic_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)),
                         q13_sat(PI_A, 1 << 30)));
    r.yaw = AW'(q13_sat(cordic_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)),
                        q13_sat(PI_A, 1 << 30)));
    s = w * y - x * z;
    r.clamped = 1'b0;
    if (s > half) begin
      s = half; r.clamped = 1'b1;
    end else if (s < -half) begin
      s = -half; r.clamped = 1'b1;
    end
    ra = floor_sqrt(one + 2 * s);
    rb = floor_sqrt(one - 2 * s);
    r.pitch = (AW-1)'(q13_sat(2 * cordic_angle(ra, rb) - HPI_A, q13_sat(HPI_A, 1 << 30)));
    return r;
  endfunction

  // Offers one quaternion and holds it until the block takes it.
  task automatic send_quat(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                           logic signed [QW-1:0] y, logic signed [QW-1:0] z);
    in_quat_w <= w; in_quat_x <= x; in_quat_y <= y; in_quat_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_angles.push_back(euler_of(w, x, y, z));
    @(negedge clk);
  endtask

  // Drops valid for a random gap that goes on while a draw comes out under 13 of 100.
  task automatic maybe_idle();
    if (!steady_sender) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  // Random component: mostly full range, sometimes an extreme or near zero.
  function automatic logic signed [QW-1:0] rand_comp();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return QW'($signed($urandom_range(64)) - 32);
      default: return QW'($urandom);
    endcase
  endfunction

  stim_row_t directed[$];

  // Adds a directed row whose result comes from the predictor.
  function automatic void add_row(int w, int x, int y, int z);
    stim_row_t r;
    r.w = QW'(w); r.x = QW'(x); r.y = QW'(y); r.z = QW'(z);
    r.has_exp = 1'b0;
    directed.push_back(r);
  endfunction

  // Adds a directed row with a hand-written result.
  function automatic void add_known(int w, int x, int y, int z,
                                    int roll, int pitch, int yaw, bit clamped);
    stim_row_t r;
    r.w = QW'(w); r.x = QW'(x); r.y = QW'(y); r.z = QW'(z);
    r.has_exp = 1'b1;
    r.exp.roll = AW'(roll); r.exp.pitch = (AW-1)'(pitch);
    r.exp.yaw = AW'(yaw); r.exp.clamped = clamped;
    directed.push_back(r);
  endfunction

  // Stimulus: directed table first, then random quaternions with pressure phases.
  initial begin
    stim_row_t row;
    logic signed [QW-1:0] qw, qx, qy, qz;
    // The all-zero quaternion: the roll and yaw vectors are not zero, as the
    // denominator terms still hold the constant one.
    add_row(0, 0, 0, 0);
    add_row(32767, 0, 0, 0);
    add_row(-32768, 0, 0, 0);
    add_row(0, 32767, 0, 0);
    add_row(0, -32768, 0, 0);
    add_row(0, 0, 32767, 0);
    add_row(0, 0, -32768, 0);
    add_row(0, 0, 0, 32767);
    add_row(0, 0, 0, -32768);
    // Full-scale components on every axis; the pitch term cancels to near zero here.
    add_row(-32768, -32768, -32768, -32768);
    add_row(32767, 32767, 32767, 32767);
    add_row(-32768, 32767, -32768, 32767);
    add_row(32767, -32768, 32767, -32768);
    add_row(23170, 0, 23170, 0);
    add_row(23170, 0, -23170, 0);
    add_row(32767, 0, 32767, 0);
    add_row(32767, 0, -32768, 0);
    add_row(16384, 16384, 16384, 16384);
    add_row(16384, -16384, 16384, -16384);
    add_row(23170, 23170, 0, 0);
    add_row(23170, 0, 0, 23170);
    add_row(1, 1, 1, 1);
    add_row(-1, -1, -1, -1);
    add_row(21845, -10923, 5461, -27000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      send_quat(row.w, row.x, row.y, row.z);
      // Hand-written rows replace the predicted value just queued.
      if (row.has_exp) pending_angles[pending_angles.size() - 1] = row.exp;
      maybe_idle();
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // A stretch where the sender never idles.
      steady_sender = (n >= 300 && n < 500);
      // The receiver holds off while items keep coming, filling the pipeline.
      if (n == 700) hold_request = 1'b1;
      // The sender pauses until every pending result has drained.
      if (n == 1100) begin
        in_valid <= 1'b0;
        while (pending_angles.size() != 0) @(negedge clk);
      end
      qw = rand_comp(); qx = rand_comp(); qy = rand_comp(); qz = rand_comp();
      // Some transactions have every component within plus or minus one half, so their pitch is not clamped.
      if ($urandom_range(3) == 0) begin
        qw = QW'($signed($urandom_range(32767)) - 16384);
        qx = QW'($signed($urandom_range(32767)) - 16384);
        qy = QW'($signed($urandom_range(32767)) - 16384);
        qz = QW'($signed($urandom_range(32767)) - 16384);
      end
      send_quat(qw, qx, qy, qz);
      maybe_idle();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off, and the comparison against the queue.
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_cycles < 200) begin
        out_stall <= 1'b1;
        hold_cycles++;
      end else begin
        out_stall <= (!steady_sender && $urandom_range(99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: result with no transaction pending: roll %0d pitch %0d yaw %0d",
                 $time, out_roll, out_pitch, out_yaw);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (out_roll !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, out_roll);
          error_count++;
        end
        if (out_pitch !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, out_pitch);
          error_count++;
        end
        if (out_yaw !== want.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, out_yaw);
          error_count++;
        end
        if (out_pitch_clamped !== want.clamped) begin
          $display("%0t: pitch_clamped expected %0b actual %0b",
                   $time, want.clamped, out_pitch_clamped);
          error_count++;
        end
      end
    end
  end

  // End of run: drain, allow the pipeline latency for stray results, then report.
  initial begin
    wait (stim_done);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("quaternion_to_euler_angles_top_tb: clean");
    end else begin
      $display("quaternion_to_euler_angles_top_tb: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #200000;
    $display("quaternion_to_euler_angles_top_tb: errors");
    $finish;
  end

endmodule

[quaternion_to_euler_angles_top.f]
rtl/qte_pkg.sv
rtl/qte_front.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/qte_back.sv
rtl/quaternion_to_euler_angles_top.sv
verif/quaternion_to_euler_angles_top_tb.sv
